/* rtl/core/blla_pkg.sv */
// Shared types and constants for the binary-lifting ancestor and LCA engine.
package blla_pkg;

    localparam int ID_W        = 10;
    localparam int KIND_W      = 2;
    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_TUSER_W = 1;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    localparam logic [ID_W-1:0] DEPTH_MAX = 10'h3FF;

    localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ANC  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LCA  = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_ANC,
        OP_LCA,
        OP_NONE
    } t_op;

    typedef struct packed {
        t_op             op;
        logic [ID_W-1:0] a;
        logic [ID_W-1:0] b;
        logic [ID_W-1:0] k;
    } t_cmd;

endpackage

/* rtl/core/binary_lifting_ancestor_lca.sv */
// Top level of the binary-lifting ancestor and lowest common ancestor engine.
//
// Requests enter on s_axis: tuser carries the kind (load, k-th ancestor, LCA),
// tdata the node ids and step count. A load attaches a node under a parent that
// must already be loaded (the block does not check this) and gives no result;
// each query gives one result on m_axis. The intake takes one request per cycle
// while the four-entry command queue has room; loads of the sentinel or of ids
// out of range and requests of an unused kind are dropped there, and queries
// with ids out of range give a not-found result. The engine runs one command at
// a time against single-write, dual-read tables: load: one table read and write
// per level; k-th ancestor: a jump per set bit of k mod 2^(LEVELS-1), then one
// top-level jump per unit of k >> (LEVELS-1); LCA: depth read, a climb as above,
// then one paired read per level walked, plus one per extra top-level step when
// LEVELS is small. A result is registered once the output register is free.
// Reset clears only control state; no clearing pass runs: the sentinel (node
// zero) is supplied by logic, and other table entries are defined once loaded.
// If the receiver stalls, the result holds, the engine finishes its next query
// and waits, and s_axis_tready drops once the queue is full.
module binary_lifting_ancestor_lca #(
    parameter int NODES  = 1024,
    parameter int LEVELS = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // node_a [9:0], node_b [19:10], step_count [29:20], zero fill [31:30]
    input  logic [blla_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // kind [1:0]
    input  logic [blla_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // result_node [9:0], zero fill [15:10]
    output logic [blla_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // found [0]
    output logic [blla_pkg::OUT_TUSER_W-1:0]    m_axis_tuser
);
    import blla_pkg::*;

    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_empty;
    t_cmd            f_cmd;
    t_cmd            q_cmd;
    logic [ID_W-1:0] res_node;
    logic            res_found;

    blla_front #(
        .NODES (NODES)
    ) u_front (
        .i_valid (s_axis_tvalid),
        .i_kind  (s_axis_tuser[KIND_W-1:0]),
        .i_a     (s_axis_tdata[ID_W-1:0]),
        .i_b     (s_axis_tdata[2*ID_W-1:ID_W]),
        .i_k     (s_axis_tdata[3*ID_W-1:2*ID_W]),
        .i_full  (q_full),
        .o_ready (s_axis_tready),
        .o_push  (q_push),
        .o_cmd   (f_cmd)
    );

    blla_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    blla_back #(
        .NODES  (NODES),
        .LEVELS (LEVELS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (q_cmd),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_node  (res_node),
        .o_found (res_found)
    );

    assign m_axis_tdata = OUT_TDATA_W'(res_node);
    assign m_axis_tuser = OUT_TUSER_W'(res_found);

endmodule

/* rtl/core/blla_front.sv */
// Request intake: range checks and sorting of requests into engine commands.
module blla_front #(
    parameter int NODES = 1024
) (
    input  logic                         i_valid,
    input  logic [blla_pkg::KIND_W-1:0]  i_kind,
    input  logic [blla_pkg::ID_W-1:0]    i_a,
    input  logic [blla_pkg::ID_W-1:0]    i_b,
    input  logic [blla_pkg::ID_W-1:0]    i_k,
    input  logic                         i_full,
    output logic                         o_ready,
    output logic                         o_push,
    output blla_pkg::t_cmd               o_cmd
);
    import blla_pkg::*;

    logic keep;
    logic a_ok;
    logic b_ok;

    assign a_ok = (32'(i_a) < NODES);
    assign b_ok = (32'(i_b) < NODES);

    always_comb begin
        keep     = 1'b0;
        o_cmd.op = OP_NONE;
        o_cmd.a  = i_a;
        o_cmd.b  = i_b;
        o_cmd.k  = i_k;
        unique case (i_kind)
            KIND_LOAD: begin
                // drop loads of the sentinel and of ids out of range
                if (i_a != '0 && a_ok && b_ok) begin
                    keep     = 1'b1;
                    o_cmd.op = OP_LOAD;
                end
            end
            KIND_ANC: begin
                keep     = 1'b1;
                o_cmd.op = a_ok ? OP_ANC : OP_NONE;
            end
            KIND_LCA: begin
                keep     = 1'b1;
                o_cmd.op = (a_ok && b_ok) ? OP_LCA : OP_NONE;
            end
            default: keep = 1'b0;
        endcase
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full && keep;

endmodule

/* rtl/core/blla_queue.sv */
// Short command queue between the intake and the engine.
module blla_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  blla_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output blla_pkg::t_cmd o_cmd,
    output logic           o_full,
    output logic           o_empty
);
    import blla_pkg::*;

    t_cmd             r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp;
    logic [QAW-1:0]   r_rp;
    logic [QAW:0]     r_cnt;
    logic [QAW-1:0]   n_wp;
    logic [QAW-1:0]   n_rp;
    logic [QAW:0]     n_cnt;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

    always_comb begin
        n_wp  = i_push ? r_wp + 1'b1 : r_wp;
        n_rp  = i_pop  ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

/* rtl/core/blla_back.sv */
// Lifting engine: depth and jump tables, load fill, climb and LCA sequencer, result register.
module blla_back #(
    parameter int NODES  = 1024,
    parameter int LEVELS = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  blla_pkg::t_cmd            i_cmd,
    input  logic                      i_empty,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [blla_pkg::ID_W-1:0] o_node,
    output logic                      o_found
);
    import blla_pkg::*;

    localparam int AW     = $clog2(NODES);
    localparam int JDEPTH = NODES * LEVELS;
    localparam int JAW    = $clog2(JDEPTH);
    localparam int LW     = $clog2(LEVELS);
    localparam int CW     = $clog2(NODES + 1);

    localparam logic [LW-1:0] LTOP  = LW'(LEVELS - 1);
    localparam logic [LW-1:0] LNEXT = LW'(LEVELS - 2);
    localparam logic [CW-1:0] NMAX  = CW'(NODES);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_LD_ISS  = 5'd1;
    localparam logic [4:0] S_LD_DEP  = 5'd2;
    localparam logic [4:0] S_LJ_ISS  = 5'd3;
    localparam logic [4:0] S_LJ_USE  = 5'd4;
    localparam logic [4:0] S_K_ISS   = 5'd5;
    localparam logic [4:0] S_K_CHK   = 5'd6;
    localparam logic [4:0] S_CL_BIT  = 5'd7;
    localparam logic [4:0] S_CL_USE  = 5'd8;
    localparam logic [4:0] S_CL_REP  = 5'd9;
    localparam logic [4:0] S_CL_RUSE = 5'd10;
    localparam logic [4:0] S_CL_END  = 5'd11;
    localparam logic [4:0] S_LC_DISS = 5'd12;
    localparam logic [4:0] S_LC_DEP  = 5'd13;
    localparam logic [4:0] S_LC_TOP  = 5'd14;
    localparam logic [4:0] S_LC_TUSE = 5'd15;
    localparam logic [4:0] S_LC_LIS  = 5'd16;
    localparam logic [4:0] S_LC_LUSE = 5'd17;
    localparam logic [4:0] S_LC_FIN  = 5'd18;
    localparam logic [4:0] S_LC_PAR  = 5'd19;
    localparam logic [4:0] S_DONE    = 5'd20;

    function automatic logic [JAW-1:0] f_jaddr(input logic [ID_W-1:0] id,
                                               input logic [LW-1:0] lvl);
        return JAW'(id) * JAW'(LEVELS) + JAW'(lvl);
    endfunction

    // tables; entry zero is never written, the sentinel is forced on read
    logic [ID_W-1:0] r_dmem [NODES];
    logic [ID_W-1:0] r_jmem [JDEPTH];

    logic [ID_W-1:0] r_dqa, r_dqb, r_jqa, r_jqb;
    logic            r_za, r_zb;
    logic [ID_W-1:0] dq_a, dq_b, jq_a, jq_b;

    logic [4:0]      r_state, n_state;
    t_op             r_op, n_op;
    logic [ID_W-1:0] r_u, n_u;
    logic [ID_W-1:0] r_v, n_v;
    logic [ID_W-1:0] r_a, n_a;
    logic [ID_W-1:0] r_k, n_k;
    logic [LW-1:0]   r_lvl, n_lvl;
    logic [CW-1:0]   r_n, n_n;
    logic [ID_W-1:0] r_res, n_res;
    logic            r_out_valid, n_out_valid;
    logic [ID_W-1:0] r_out_node;

    logic            out_free;
    logic            out_load;
    logic            w_jen, w_den;
    logic [JAW-1:0]  w_jaddr;
    logic [ID_W-1:0] w_jdata;
    logic [AW-1:0]   w_daddr;
    logic [ID_W-1:0] w_ddata;

    assign dq_a = r_za ? '0 : r_dqa;
    assign dq_b = r_zb ? '0 : r_dqb;
    assign jq_a = r_za ? '0 : r_jqa;
    assign jq_b = r_zb ? '0 : r_jqb;

    always_ff @(posedge i_clk) begin
        if (w_den) begin
            r_dmem[w_daddr] <= w_ddata;
        end
        if (w_jen) begin
            r_jmem[w_jaddr] <= w_jdata;
        end
        r_dqa <= r_dmem[AW'(r_u)];
        r_dqb <= r_dmem[AW'(r_v)];
        r_jqa <= r_jmem[f_jaddr(r_u, r_lvl)];
        r_jqb <= r_jmem[f_jaddr(r_v, r_lvl)];
        r_za  <= (r_u == '0);
        r_zb  <= (r_v == '0);
    end

    assign out_free = !r_out_valid || i_ready;
    assign out_load = (r_state == S_DONE) && out_free;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_u     = r_u;
        n_v     = r_v;
        n_a     = r_a;
        n_k     = r_k;
        n_lvl   = r_lvl;
        n_n     = r_n;
        n_res   = r_res;
        o_pop   = 1'b0;
        w_den   = 1'b0;
        w_daddr = AW'(r_a);
        w_ddata = (dq_a == DEPTH_MAX) ? DEPTH_MAX : dq_a + ID_W'(1);
        w_jen   = 1'b0;
        w_jaddr = f_jaddr(r_a, LW'(r_lvl + 1'b1));
        w_jdata = jq_a;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_op  = i_cmd.op;
                    unique case (i_cmd.op)
                        OP_LOAD: begin
                            n_a     = i_cmd.a;
                            n_u     = i_cmd.b;
                            n_lvl   = '0;
                            n_state = S_LD_ISS;
                        end
                        OP_ANC: begin
                            n_u     = i_cmd.a;
                            n_k     = i_cmd.k;
                            n_state = S_K_ISS;
                        end
                        OP_LCA: begin
                            n_u = i_cmd.a;
                            n_v = i_cmd.b;
                            if (i_cmd.a == i_cmd.b) begin
                                n_res   = i_cmd.a;
                                n_state = S_DONE;
                            end else begin
                                n_state = S_LC_DISS;
                            end
                        end
                        default: begin
                            n_res   = '0;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_LD_ISS: n_state = S_LD_DEP;
            S_LD_DEP: begin
                w_den   = 1'b1;
                w_jen   = 1'b1;
                w_jaddr = f_jaddr(r_a, '0);
                w_jdata = r_u;
                n_state = S_LJ_ISS;
            end
            S_LJ_ISS: n_state = S_LJ_USE;
            S_LJ_USE: begin
                // level i+1 is level i of the node that level i points to
                w_jen = 1'b1;
                n_u   = jq_a;
                if (r_lvl == LNEXT) begin
                    n_state = S_IDLE;
                end else begin
                    n_lvl   = r_lvl + 1'b1;
                    n_state = S_LJ_ISS;
                end
            end
            S_K_ISS: n_state = S_K_CHK;
            S_K_CHK: begin
                if (r_k > dq_a) begin
                    n_res   = '0;
                    n_state = S_DONE;
                end else begin
                    n_lvl   = '0;
                    n_state = S_CL_BIT;
                end
            end
            S_CL_BIT: begin
                if (r_lvl == LTOP) begin
                    n_n     = '0;
                    n_state = S_CL_REP;
                end else if (r_k[0]) begin
                    n_state = S_CL_USE;
                end else begin
                    n_k   = r_k >> 1;
                    n_lvl = r_lvl + 1'b1;
                end
            end
            S_CL_USE: begin
                n_u     = jq_a;
                n_k     = r_k >> 1;
                n_lvl   = r_lvl + 1'b1;
                n_state = S_CL_BIT;
            end
            S_CL_REP: begin
                // what is left of the step count repeats the top level
                if (r_k == '0 || r_n == NMAX) begin
                    n_state = S_CL_END;
                end else begin
                    n_state = S_CL_RUSE;
                end
            end
            S_CL_RUSE: begin
                n_u     = jq_a;
                n_k     = r_k - ID_W'(1);
                n_n     = r_n + 1'b1;
                n_state = S_CL_REP;
            end
            S_CL_END: begin
                if (r_op != OP_LCA || r_u == r_v) begin
                    n_res   = r_u;
                    n_state = S_DONE;
                end else begin
                    n_n     = '0;
                    n_state = S_LC_TOP;
                end
            end
            S_LC_DISS: n_state = S_LC_DEP;
            S_LC_DEP: begin
                // keep the deeper node in u and climb it by the depth gap
                if (dq_a < dq_b) begin
                    n_u = r_v;
                    n_v = r_u;
                    n_k = dq_b - dq_a;
                end else begin
                    n_k = dq_a - dq_b;
                end
                n_lvl   = '0;
                n_state = S_CL_BIT;
            end
            S_LC_TOP: begin
                if (r_n == NMAX) begin
                    n_lvl   = LNEXT;
                    n_state = S_LC_LIS;
                end else begin
                    n_state = S_LC_TUSE;
                end
            end
            S_LC_TUSE: begin
                if (jq_a != jq_b) begin
                    n_u     = jq_a;
                    n_v     = jq_b;
                    n_n     = r_n + 1'b1;
                    n_state = S_LC_TOP;
                end else begin
                    n_lvl   = LNEXT;
                    n_state = S_LC_LIS;
                end
            end
            S_LC_LIS: n_state = S_LC_LUSE;
            S_LC_LUSE: begin
                if (jq_a != jq_b) begin
                    n_u = jq_a;
                    n_v = jq_b;
                end
                if (r_lvl == '0) begin
                    n_state = S_LC_FIN;
                end else begin
                    n_lvl   = r_lvl - 1'b1;
                    n_state = S_LC_LIS;
                end
            end
            S_LC_FIN: begin
                if (r_u == r_v) begin
                    n_res   = r_u;
                    n_state = S_DONE;
                end else begin
                    n_state = S_LC_PAR;
                end
            end
            S_LC_PAR: begin
                n_res   = jq_a;
                n_state = S_DONE;
            end
            S_DONE: begin
                // hold until the result register frees up
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_u   <= n_u;
        r_v   <= n_v;
        r_a   <= n_a;
        r_k   <= n_k;
        r_lvl <= n_lvl;
        r_n   <= n_n;
        r_res <= n_res;
        if (out_load) begin
            r_out_node <= r_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_node  = r_out_node;
    assign o_found = (r_out_node != '0);

endmodule
